[sv/rsnh_pkg.sv]
// Shared types, constants and pipeline step functions for the ray-sphere hit unit.
package rsnh_pkg;

    localparam int unsigned SQ_STAGES = 32;
    localparam int unsigned DV_STAGES = 31;
    localparam logic [30:0] DIST_MAX  = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CFG_CAMERA_X = 2'd0,
        CFG_CAMERA_Y = 2'd1,
        CFG_CAMERA_Z = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [21:0]        ray_index;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        sphere_radius;
        logic [30:0]        nearest_so_far;
    } t_in_word;

    typedef struct packed {
        logic [21:0] ray_index_out;
        logic        is_closer;
        logic [30:0] hit_distance;
        logic [30:0] new_nearest;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_cam;

    // Fields of the item that ride along unchanged until the end.
    typedef struct packed {
        logic [21:0] ray_index;
        logic [30:0] nearest;
    } t_tag;

    typedef struct packed {
        logic               have;
        logic [30:0]        a;
        logic signed [31:0] b;
        t_tag               tag;
    } t_disc;

    typedef struct packed {
        logic valid;
        logic ovf;
        t_tag tag;
    } t_quot;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sq_st;

    typedef struct packed {
        logic [31:0] rem;
        logic [30:0] q;
        logic [30:0] lo;
        logic [31:0] den;
    } t_dv_st;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] x);
        logic signed [50:0] hi;
        logic signed [50:0] lo;
        hi = 51'sd2147483647;
        lo = -51'sd2147483648;
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [50:0] sx48(input logic signed [47:0] x);
        return {{3{x[47]}}, x};
    endfunction

    // One result bit of the digit-by-digit square root.
    function automatic t_sq_st sqrt_step(input t_sq_st st);
        logic [35:0] sh;
        logic [35:0] trial;
        logic [35:0] diff;
        t_sq_st      nx;
        sh     = {st.rem, st.rad[63:62]};
        trial  = {2'b00, st.root, 2'b01};
        diff   = sh - trial;
        nx.rad = {st.rad[61:0], 2'b00};
        if (sh >= trial) begin
            nx.rem  = diff[33:0];
            nx.root = {st.root[30:0], 1'b1};
        end else begin
            nx.rem  = sh[33:0];
            nx.root = {st.root[30:0], 1'b0};
        end
        return nx;
    endfunction

    // One quotient bit of the restoring divider.
    function automatic t_dv_st div_step(input t_dv_st st);
        logic [32:0] sh;
        logic [32:0] diff;
        t_dv_st      nx;
        sh     = {st.rem, st.lo[30]};
        diff   = sh - {1'b0, st.den};
        nx.lo  = {st.lo[29:0], 1'b0};
        nx.den = st.den;
        if (sh >= {1'b0, st.den}) begin
            nx.rem = diff[31:0];
            nx.q   = {st.q[29:0], 1'b1};
        end else begin
            nx.rem = sh[31:0];
            nx.q   = {st.q[29:0], 1'b0};
        end
        return nx;
    endfunction

endpackage

[sv/rsnh_geom.sv]
// Five-stage front end: offsets, products, quadratic coefficients and discriminant.
module rsnh_geom (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rsnh_pkg::t_in_word i_word,
    input  rsnh_pkg::t_cam   i_cam,
    output logic             o_valid,
    output logic [63:0]      o_delta,
    output rsnh_pkg::t_disc  o_disc
);
    import rsnh_pkg::*;

    logic [4:0] r_v;

    logic signed [31:0] r1_d [3];
    logic signed [31:0] r1_w [3];
    logic [30:0]        r1_r;
    t_tag               r1_tag;

    logic signed [47:0] r2_dd [3];
    logic signed [47:0] r2_dw [3];
    logic signed [47:0] r2_ww [3];
    logic [45:0]        r2_rr;
    t_tag               r2_tag;

    logic [30:0]        r3_a;
    logic signed [31:0] r3_b;
    logic signed [31:0] r3_c;
    t_tag               r3_tag;

    logic [63:0]        r4_b2;
    logic [63:0]        r4_fac;
    logic               r4_cpos;
    logic               r4_apos;
    logic [30:0]        r4_a;
    logic signed [31:0] r4_b;
    t_tag               r4_tag;

    logic [63:0]        r5_delta;
    t_disc              r5_disc;

    logic signed [31:0] n1_d [3];
    logic signed [31:0] n1_o [3];
    logic signed [31:0] n1_p [3];
    logic signed [31:0] n1_w [3];
    logic signed [32:0] n1_dif [3];
    logic signed [63:0] n2_pdd [3];
    logic signed [63:0] n2_pdw [3];
    logic signed [63:0] n2_pww [3];
    logic [61:0]        n2_prr;
    logic signed [50:0] n3_sa;
    logic signed [50:0] n3_sb;
    logic signed [50:0] n3_sb2;
    logic signed [50:0] n3_sc;
    logic signed [31:0] n3_a;
    logic signed [63:0] n4_b2;
    logic [31:0]        n4_cmag;
    logic [62:0]        n4_ac;
    logic [64:0]        n5_sum;
    logic [63:0]        n5_delta;
    logic               n5_have;

    always_comb begin
        n1_d[0] = i_word.dir_x;
        n1_d[1] = i_word.dir_y;
        n1_d[2] = i_word.dir_z;
        n1_o[0] = i_word.center_x;
        n1_o[1] = i_word.center_y;
        n1_o[2] = i_word.center_z;
        n1_p[0] = i_cam.x;
        n1_p[1] = i_cam.y;
        n1_p[2] = i_cam.z;
        for (int k = 0; k < 3; k++) begin
            n1_dif[k] = {n1_p[k][31], n1_p[k]} - {n1_o[k][31], n1_o[k]};
            n1_w[k]   = sat32({{18{n1_dif[k][32]}}, n1_dif[k]});
        end
    end

    // Taking bits 63:16 of a signed product is the floor of a divide by 2^16.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_pdd[k] = r1_d[k] * r1_d[k];
            n2_pdw[k] = r1_d[k] * r1_w[k];
            n2_pww[k] = r1_w[k] * r1_w[k];
        end
        n2_prr = r1_r * r1_r;
    end

    always_comb begin
        n3_sa  = sx48(r2_dd[0]) + sx48(r2_dd[1]) + sx48(r2_dd[2]);
        n3_sb  = sx48(r2_dw[0]) + sx48(r2_dw[1]) + sx48(r2_dw[2]);
        n3_sb2 = {n3_sb[49:0], 1'b0};
        n3_sc  = sx48(r2_ww[0]) + sx48(r2_ww[1]) + sx48(r2_ww[2])
                 - {5'b0, r2_rr};
        n3_a   = sat32(n3_sa);
    end

    always_comb begin
        n4_b2   = r3_b * r3_b;
        n4_cmag = r3_c[31] ? (~r3_c + 32'd1) : r3_c;
        n4_ac   = r3_a * n4_cmag;
    end

    always_comb begin
        n5_sum = {1'b0, r4_b2} + {1'b0, r4_fac};
        if (r4_cpos) begin
            n5_have  = r4_apos && (r4_b2 >= r4_fac);
            n5_delta = r4_b2 - r4_fac;
        end else begin
            n5_have  = r4_apos;
            n5_delta = n5_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : n5_sum[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_d[k]  <= n1_d[k];
            r1_w[k]  <= n1_w[k];
            r2_dd[k] <= n2_pdd[k][63:16];
            r2_dw[k] <= n2_pdw[k][63:16];
            r2_ww[k] <= n2_pww[k][63:16];
        end
        r1_r             <= i_word.sphere_radius;
        r1_tag.ray_index <= i_word.ray_index;
        r1_tag.nearest   <= i_word.nearest_so_far;

        r2_rr  <= n2_prr[61:16];
        r2_tag <= r1_tag;

        r3_a   <= n3_a[30:0];
        r3_b   <= sat32(n3_sb2);
        r3_c   <= sat32(n3_sc);
        r3_tag <= r2_tag;

        r4_b2   <= n4_b2;
        r4_fac  <= {n4_ac[61:0], 2'b00};
        r4_cpos <= !r3_c[31] && (r3_c != 32'sd0);
        r4_apos <= (r3_a != 31'd0);
        r4_a    <= r3_a;
        r4_b    <= r3_b;
        r4_tag  <= r3_tag;

        r5_delta     <= n5_delta;
        r5_disc.have <= n5_have;
        r5_disc.a    <= r4_a;
        r5_disc.b    <= r4_b;
        r5_disc.tag  <= r4_tag;
    end

    assign o_valid = r_v[4];
    assign o_delta = r5_delta;
    assign o_disc  = r5_disc;

endmodule

[sv/rsnh_sqrt.sv]
// Pipelined integer square root of the discriminant, one result bit per stage.
module rsnh_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [63:0]     i_radicand,
    input  rsnh_pkg::t_disc i_disc,
    output logic            o_valid,
    output logic [31:0]     o_root,
    output rsnh_pkg::t_disc o_disc
);
    import rsnh_pkg::*;

    logic [SQ_STAGES-1:0] r_v;
    t_sq_st               r_st   [SQ_STAGES];
    t_disc                r_side [SQ_STAGES];
    t_sq_st               n_init;

    always_comb begin
        n_init.rem  = '0;
        n_init.root = '0;
        n_init.rad  = i_radicand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[SQ_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0]   <= sqrt_step(n_init);
        r_side[0] <= i_disc;
        for (int g = 1; g < SQ_STAGES; g++) begin
            r_st[g]   <= sqrt_step(r_st[g-1]);
            r_side[g] <= r_side[g-1];
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_st[SQ_STAGES-1].root;
    assign o_disc  = r_side[SQ_STAGES-1];

endmodule

[sv/rsnh_div.sv]
// Pipelined restoring divider giving a 31-bit quotient, one quotient bit per stage.
module rsnh_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [32:0]     i_num,
    input  logic [31:0]     i_den,
    input  rsnh_pkg::t_quot i_quot,
    output logic            o_valid,
    output logic [30:0]     o_q,
    output rsnh_pkg::t_quot o_quot
);
    import rsnh_pkg::*;

    logic [DV_STAGES-1:0] r_v;
    t_dv_st               r_st   [DV_STAGES];
    t_quot                r_side [DV_STAGES];
    t_dv_st               n_init;

    // The dividend is the numerator scaled by 2^16; its top 18 bits seed the remainder.
    always_comb begin
        n_init.rem = {14'd0, i_num[32:15]};
        n_init.q   = '0;
        n_init.lo  = {i_num[14:0], 16'd0};
        n_init.den = i_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0]   <= div_step(n_init);
        r_side[0] <= i_quot;
        for (int g = 1; g < DV_STAGES; g++) begin
            r_st[g]   <= div_step(r_st[g-1]);
            r_side[g] <= r_side[g-1];
        end
    end

    assign o_valid = r_v[DV_STAGES-1];
    assign o_q     = r_st[DV_STAGES-1].q;
    assign o_quot  = r_side[DV_STAGES-1];

endmodule

[sv/ray_sphere_nearest_hit_unit.sv]
// Ray-sphere nearest hit unit: fully pipelined, one word accepted every cycle.
// The path has 5 coefficient stages, 32 square-root stages, 2 root-select stages,
// 31 divider stages and 1 output register before the result strobe.
// Throughput is one word per cycle; o_busy stays low and results cannot be held off.
// Synchronous active-low reset clears the camera registers and all valid bits.
module ray_sphere_nearest_hit_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  rsnh_pkg::t_in_word  i_word,
    output logic                o_valid,
    output rsnh_pkg::t_out_word o_word,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata
);
    import rsnh_pkg::*;

    t_cam        r_cam;

    logic        w_geo_v;
    logic [63:0] w_delta;
    t_disc       w_geo_disc;
    logic        w_sq_v;
    logic [31:0] w_root;
    t_disc       w_sq_disc;
    logic        w_dv_v;
    logic [30:0] w_q;
    t_quot       w_dv_quot;

    logic               r_sel_v;
    logic [32:0]        r_sel_n;
    logic [31:0]        r_sel_den;
    logic               r_sel_vld;
    t_tag               r_sel_tag;
    logic               r_ck_v;
    logic [32:0]        r_ck_n;
    logic [31:0]        r_ck_den;
    t_quot              r_ck_quot;
    logic               r_out_v;
    t_out_word          r_out_word;

    logic signed [33:0] n_negb;
    logic signed [33:0] n_n0;
    logic signed [33:0] n_n1;
    logic [30:0]        n_sol;
    logic               n_closer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAMERA_X: r_cam.x <= i_cfg_wdata;
                CFG_CAMERA_Y: r_cam.y <= i_cfg_wdata;
                CFG_CAMERA_Z: r_cam.z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    rsnh_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_word  (i_word),
        .i_cam   (r_cam),
        .o_valid (w_geo_v),
        .o_delta (w_delta),
        .o_disc  (w_geo_disc)
    );

    rsnh_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_geo_v),
        .i_radicand (w_delta),
        .i_disc     (w_geo_disc),
        .o_valid    (w_sq_v),
        .o_root     (w_root),
        .o_disc     (w_sq_disc)
    );

    // The minus root never exceeds the plus root, and a root is non-negative exactly
    // when its numerator is, so one division of the chosen numerator suffices.
    always_comb begin
        n_negb = -{{2{w_sq_disc.b[31]}}, w_sq_disc.b};
        n_n0   = n_negb + {2'b00, w_root};
        n_n1   = n_negb - {2'b00, w_root};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_v <= 1'b0;
            r_ck_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_sel_v <= w_sq_v;
            r_ck_v  <= r_sel_v;
            r_out_v <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel_vld <= w_sq_disc.have && !n_n0[33];
        r_sel_n   <= !n_n1[33] ? n_n1[32:0] : n_n0[32:0];
        r_sel_den <= {w_sq_disc.a, 1'b0};
        r_sel_tag <= w_sq_disc.tag;

        // A quotient of 2^31 or more is clamped; that is numerator >= den * 2^15.
        r_ck_n          <= r_sel_n;
        r_ck_den        <= r_sel_den;
        r_ck_quot.valid <= r_sel_vld;
        r_ck_quot.ovf   <= ({14'd0, r_sel_n} >= {r_sel_den, 15'd0});
        r_ck_quot.tag   <= r_sel_tag;
    end

    rsnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_ck_v),
        .i_num   (r_ck_n),
        .i_den   (r_ck_den),
        .i_quot  (r_ck_quot),
        .o_valid (w_dv_v),
        .o_q     (w_q),
        .o_quot  (w_dv_quot)
    );

    always_comb begin
        if (!w_dv_quot.valid) begin
            n_sol = '0;
        end else if (w_dv_quot.ovf) begin
            n_sol = DIST_MAX;
        end else begin
            n_sol = w_q;
        end
        n_closer = w_dv_quot.valid && (n_sol <= w_dv_quot.tag.nearest);
    end

    always_ff @(posedge i_clk) begin
        r_out_word.ray_index_out <= w_dv_quot.tag.ray_index;
        r_out_word.is_closer     <= n_closer;
        r_out_word.hit_distance  <= n_sol;
        r_out_word.new_nearest   <= n_closer ? n_sol : w_dv_quot.tag.nearest;
    end

    assign o_valid = r_out_v;
    assign o_word  = r_out_word;

endmodule
